// ----- design/nbc_pkg.sv -----
package nbc_pkg;

  localparam int unsigned PayloadBitsDef = 48;
  localparam int unsigned WordBits       = 64;

  localparam logic [63:0] QnanBits  = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] CanonNan  = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] NilPay    = 64'h0000_0000_0000_0001;

  typedef enum logic [2:0] {
    ActNil    = 3'd0,
    ActNat    = 3'd1,
    ActInt    = 3'd2,
    ActFloat  = 3'd3,
    ActCell   = 3'd4,
    ActDecode = 3'd5
  } nbc_action_e;

  typedef enum logic [2:0] {
    KindNil  = 3'd0,
    KindNat  = 3'd1,
    KindInt  = 3'd2,
    KindFlo  = 3'd3,
    KindCell = 3'd4
  } nbc_kind_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] operand_bits;
  } nbc_req_t;

  typedef struct packed {
    logic [63:0] box_word;
    logic [2:0]  kind;
    logic [63:0] payload;
    logic        is_heap_ref;
    logic        range_fault;
  } nbc_rsp_t;

endpackage

// ----- design/nan_box_codec_unit.sv -----
// NaN-boxing encoder/decoder. Each request packs nil, a natural, a signed
// integer or a cell pointer into a quiet-NaN box (tag at bits 50..48, payload
// in the low PAYLOAD_BITS bits), passes a double through with any quiet-NaN
// pattern made canonical, or decodes a box word; every response carries the
// box word with its kind, payload, heap-reference flag and a range fault for
// operands that do not fit the payload. One request is accepted per clock
// while the stages are not stalled. An accepted request is held in the
// request register, and the encode and decode logic between the two
// registers loads its response into the response register, which drives
// out_valid_o and out_o. Back-pressure on the response side stalls both
// stages.
module nan_box_codec_unit
  import nbc_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  nbc_req_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nbc_rsp_t out_o
);

  localparam int unsigned ExtBits = WordBits - PAYLOAD_BITS;
  localparam logic [63:0] PayMask = (64'd1 << PAYLOAD_BITS) - 64'd1;

  logic     req_valid_q;
  nbc_req_t req_q;
  logic     rsp_valid_q;
  nbc_rsp_t rsp_q;
  nbc_rsp_t rsp_d;
  logic     rsp_ready;
  logic     req_ready;

  logic [63:0] opnd;
  logic [63:0] opnd_sext;
  logic [63:0] box;
  logic [63:0] box_sext;
  logic [2:0]  enc_tag;
  logic        fault;
  logic        box_is_float;
  logic [2:0]  dec_kind;

  assign rsp_ready  = !rsp_valid_q || out_ready_i;
  assign req_ready  = !req_valid_q || rsp_ready;
  assign in_ready_o = req_ready;

  assign opnd      = req_q.operand_bits;
  assign opnd_sext = {{ExtBits{opnd[PAYLOAD_BITS-1]}}, opnd[PAYLOAD_BITS-1:0]};

  always_comb begin
    box     = opnd;
    fault   = 1'b0;
    enc_tag = KindNil;
    unique case (req_q.action)
      ActNil: begin
        enc_tag = KindNil;
        box     = QnanBits | {13'd0, enc_tag, 48'd0} | (NilPay & PayMask);
      end
      ActNat: begin
        enc_tag = KindNat;
        fault   = (opnd & ~PayMask) != 64'd0;
        box     = QnanBits | {13'd0, enc_tag, 48'd0} | (opnd & PayMask);
      end
      ActInt: begin
        enc_tag = KindInt;
        fault   = opnd_sext != opnd;
        box     = QnanBits | {13'd0, enc_tag, 48'd0} | (opnd & PayMask);
      end
      ActFloat: begin
        box = ((opnd & QnanBits) == QnanBits) ? CanonNan : opnd;
      end
      ActCell: begin
        enc_tag = KindCell;
        fault   = opnd_sext != opnd;
        box     = QnanBits | {13'd0, enc_tag, 48'd0} | (opnd & PayMask);
      end
      default: begin
        box = opnd;
      end
    endcase
  end

  // decode view of the box
  assign box_sext     = {{ExtBits{box[PAYLOAD_BITS-1]}}, box[PAYLOAD_BITS-1:0]};
  assign box_is_float = ((box & QnanBits) != QnanBits) || (box == CanonNan);
  assign dec_kind     = box[50:48];

  always_comb begin
    rsp_d.box_word    = box;
    rsp_d.range_fault = fault;
    if (box_is_float) begin
      rsp_d.kind        = KindFlo;
      rsp_d.payload     = box;
      rsp_d.is_heap_ref = 1'b0;
    end else begin
      rsp_d.kind        = dec_kind;
      rsp_d.payload     = (dec_kind == KindNat) ? (box & PayMask) : box_sext;
      rsp_d.is_heap_ref = dec_kind[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_ready) begin
        req_valid_q <= in_valid_i;
      end
      if (rsp_ready) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && in_valid_i) begin
      req_q <= in_i;
    end
    if (rsp_ready && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_o       = rsp_q;

`ifndef SYNTH
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> req_valid_q)
    else $error("accepted request not held in request stage");

  a_req_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !rsp_ready) |=> (req_valid_q && $stable(req_q)))
    else $error("stalled request stage lost its request");

  a_fault_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.range_fault) |->
      (out_o.kind == KindNat || out_o.kind == KindInt || out_o.kind == KindCell))
    else $error("range fault on a kind that cannot fault");

  a_box_qnan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.kind != KindFlo) |-> (out_o.box_word[62:51] == 12'hfff))
    else $error("non-float kind without quiet-NaN bits");
`endif

endmodule

// ----- tb/tb_nan_box_codec_unit.sv -----
module tb_nan_box_codec_unit;
  import nbc_pkg::*;

  localparam int unsigned PayW      = PayloadBitsDef;
  localparam int unsigned TagShift  = 48;
  localparam logic [63:0] PayMask   = (64'd1 << PayW) - 64'd1;
  localparam logic [63:0] PaySign   = 64'd1 << (PayW - 1);
  localparam logic [2:0]  ActSpare6 = 3'd6;
  localparam logic [2:0]  ActSpare7 = 3'd7;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 150;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  nbc_req_t in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  nbc_rsp_t out_o;

  nbc_rsp_t    pending_boxes[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned rx_hold;
  bit          idle_on;

  nan_box_codec_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sext_pay(logic [63:0] w);
    logic [63:0] p;
    p = w & PayMask;
    return (p ^ PaySign) - PaySign;
  endfunction

  function automatic logic [63:0] pack_box(logic [2:0] tag, logic [63:0] pay);
    return QnanBits | (64'(tag) << TagShift) | (pay & PayMask);
  endfunction

  function automatic nbc_rsp_t predict_box(nbc_req_t req);
    nbc_rsp_t    rsp;
    logic [63:0] v;
    logic [63:0] w;
    v   = req.operand_bits;
    rsp = '0;
    case (req.action)
      ActNil: begin
        w = pack_box(KindNil, NilPay);
      end
      ActNat: begin
        rsp.range_fault = (v & ~PayMask) != 64'd0;
        w = pack_box(KindNat, v);
      end
      ActInt: begin
        rsp.range_fault = sext_pay(v) != v;
        w = pack_box(KindInt, v);
      end
      ActFloat: begin
        w = ((v & QnanBits) == QnanBits) ? CanonNan : v;
      end
      ActCell: begin
        rsp.range_fault = sext_pay(v) != v;
        w = pack_box(KindCell, v);
      end
      default: begin
        w = v;
      end
    endcase
    rsp.box_word = w;
    if (((w & QnanBits) != QnanBits) || (w == CanonNan)) begin
      rsp.kind        = KindFlo;
      rsp.payload     = w;
      rsp.is_heap_ref = 1'b0;
    end else begin
      rsp.kind        = w[TagShift+2:TagShift];
      rsp.payload     = (rsp.kind == KindNat) ? (w & PayMask) : sext_pay(w);
      rsp.is_heap_ref = rsp.kind > KindFlo;
    end
    return rsp;
  endfunction

  function automatic logic [63:0] rand_operand(logic [2:0] act);
    logic [63:0] r;
    int unsigned shape;
    r     = {$urandom, $urandom};
    shape = $urandom_range(0, 5);
    if (act >= ActDecode && $urandom_range(0, 1) == 1) shape = 3;
    case (shape)
      0: return r;
      1: return r & PayMask;
      2: return sext_pay(r);
      3: return QnanBits | {$urandom_range(0, 1) == 1, 63'd0}
                | (64'($urandom_range(0, 7)) << TagShift) | (r & PayMask);
      4: begin
        case ($urandom_range(0, 7))
          0: return 64'd0;
          1: return '1;
          2: return PayMask;
          3: return PaySign;
          4: return PaySign - 64'd1;
          5: return ~(PaySign - 64'd1);
          6: return CanonNan;
          default: return 64'h7ff0_0000_0000_0000;
        endcase
      end
      default: return sext_pay(r) ^ (64'd1 << $urandom_range(PayW, 63));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_req(logic [2:0] act, logic [63:0] operand);
    int unsigned gap;
    nbc_req_t    req;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    req.action       = act;
    req.operand_bits = operand;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i       = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_boxes.push_back(predict_box(req));
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold != 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (rx_hold) @(negedge clk_i);
        rx_hold = 0;
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    nbc_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch("unexpected response", out_o.box_word, 64'd0);
      end else begin
        want = pending_boxes.pop_front();
        if (out_o.box_word !== want.box_word)
          report_mismatch("box_word", out_o.box_word, want.box_word);
        if (out_o.kind !== want.kind)
          report_mismatch("kind", 64'(out_o.kind), 64'(want.kind));
        if (out_o.payload !== want.payload)
          report_mismatch("payload", out_o.payload, want.payload);
        if (out_o.is_heap_ref !== want.is_heap_ref)
          report_mismatch("is_heap_ref", 64'(out_o.is_heap_ref), 64'(want.is_heap_ref));
        if (out_o.range_fault !== want.range_fault)
          report_mismatch("range_fault", 64'(out_o.range_fault), 64'(want.range_fault));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_encode_edges;
    idle_on = 1'b1;
    send_req(ActNil, '1);
    send_req(ActNat, 64'd0);
    send_req(ActNat, PayMask);
    send_req(ActNat, '1);
    send_req(ActInt, '1);
    send_req(ActInt, PaySign - 64'd1);
    send_req(ActInt, ~(PaySign - 64'd1));
    send_req(ActInt, PaySign);
    send_req(ActFloat, 64'hfff8_0000_0000_0001);
    send_req(ActFloat, 64'h7ff0_0000_0000_0000);
    send_req(ActFloat, 64'h7ff4_0000_0000_0000);
    send_req(ActCell, ~(PaySign - 64'd1));
    send_req(ActCell, 64'h0001_0000_0000_0000);
  endtask

  task automatic test_decode_edges;
    idle_on = 1'b1;
    send_req(ActDecode, 64'h7ff8_0000_0000_0001);
    send_req(ActDecode, 64'hfffa_8000_0000_0000);
    send_req(ActDecode, 64'h7fff_ffff_ffff_ffff);
    send_req(ActDecode, 64'h7ffd_0000_0000_0000);
    send_req(ActDecode, CanonNan);
    send_req(ActDecode, 64'h3ff0_0000_0000_0000);
    send_req(ActSpare6, 64'h7ff9_8000_0000_0000);
    send_req(ActSpare7, 64'h7ffc_0000_0000_0001);
  endtask

  task automatic test_random_traffic(int unsigned n, bit with_idle);
    logic [2:0] act;
    idle_on = with_idle;
    repeat (n) begin
      act = 3'($urandom_range(0, 7));
      send_req(act, rand_operand(act));
    end
  endtask

  task automatic test_receiver_hold;
    logic [2:0] act;
    idle_on = 1'b0;
    rx_hold = HoldCycles;
    repeat (60) begin
      act = 3'($urandom_range(0, 7));
      send_req(act, rand_operand(act));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    rx_hold        = 0;
    idle_on        = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_encode_edges();
    test_decode_edges();
    test_random_traffic(150, 1'b0);
    test_receiver_hold();
    test_random_traffic(450, 1'b1);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- nan_box_codec_unit.f -----
design/nbc_pkg.sv
design/nan_box_codec_unit.sv
tb/tb_nan_box_codec_unit.sv
